FILE: sv/bntt_pkg.sv
// Shared types, constants and helper functions for the byte NTT core.
package bntt_pkg;

    // transform size and field
    localparam int NPTS       = 8;
    localparam int BYTE_W     = 8;
    localparam int VAL_W      = 9;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int CNT_W      = 5;
    localparam int TERM_W     = VAL_W + 1;
    localparam int PAIR_W     = TERM_W + 1;
    localparam int SUM_W      = PAIR_W + 2;
    localparam int RED_W      = 15;

    localparam logic [VAL_W-1:0]  FIELD_Q      = 9'd257;
    localparam logic [VAL_W-1:0]  CENTRE_LIM   = 9'd128;
    // adding 255 modulo 512 is the same as subtracting 257
    localparam logic [VAL_W-1:0]  NEG_Q_MOD512 = 9'd255;
    localparam logic [RED_W-1:0]  SUM_OFFSET   = 15'd4112;   // 16 * 257
    localparam logic [VAL_W:0]    ZERO_MOD_EFF = 10'd512;

    // register reset values
    localparam logic [VAL_W-1:0] ROOT_RST    = 9'd2;
    localparam logic [VAL_W-1:0] MODULUS_RST = 9'd257;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b1;

    // power generator states
    typedef enum logic [1:0] {
        PW_IDLE,
        PW_MUL,
        PW_DIV
    } pw_state_t;

    // power table handed from the generator to the datapath
    typedef struct packed {
        logic                            busy;
        logic [NPTS-1:0][VAL_W-1:0]      pow;
    } pow_tab_t;

    // bit-reverse a 3-bit column index
    function automatic logic [IDX_W-1:0] rev3(input logic [IDX_W-1:0] v);
        return {v[0], v[1], v[2]};
    endfunction

    // exponent of the matrix entry in row j for input bit k
    function automatic logic [3:0] exp_of(input int j, input int k);
        logic [IDX_W-1:0] c;
        logic [7:0]       prod;
        c    = rev3(IDX_W'(k));
        prod = 8'(c) * 8'(2 * j + 1);
        return prod[3:0];
    endfunction

    // fold a sum into -128..128 modulo 257
    function automatic logic signed [VAL_W-1:0] reduce_centre(
        input logic signed [SUM_W-1:0] s
    );
        logic [RED_W-1:0] x;
        logic [VAL_W:0]   d;
        logic [VAL_W-1:0] r;
        x = RED_W'(s) + SUM_OFFSET;
        // 256 is -1 mod 257: fold the high part down
        d = {2'b00, x[7:0]} - {3'b000, x[RED_W-1:8]};
        if (d[VAL_W])
        begin
            d = d + {1'b0, FIELD_Q};
        end
        r = d[VAL_W-1:0];
        if (r > CENTRE_LIM)
        begin
            r = r + NEG_Q_MOD512;
        end
        return $signed(r);
    endfunction

endpackage

FILE: sv/bntt_if.sv
// Valid/ready channel interfaces for the input byte and the coefficient word.
interface bntt_in_if;
    logic                          valid;
    logic                          ready;
    logic [bntt_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface bntt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bntt_pkg::VAL_W-1:0]   coeff_0;
    logic signed [bntt_pkg::VAL_W-1:0]   coeff_1;
    logic signed [bntt_pkg::VAL_W-1:0]   coeff_2;
    logic signed [bntt_pkg::VAL_W-1:0]   coeff_3;
    logic signed [bntt_pkg::VAL_W-1:0]   coeff_4;
    logic signed [bntt_pkg::VAL_W-1:0]   coeff_5;
    logic signed [bntt_pkg::VAL_W-1:0]   coeff_6;
    logic signed [bntt_pkg::VAL_W-1:0]   coeff_7;

    modport source (output valid, output coeff_0, output coeff_1, output coeff_2,
                    output coeff_3, output coeff_4, output coeff_5, output coeff_6,
                    output coeff_7, input ready);
    modport sink   (input valid, input coeff_0, input coeff_1, input coeff_2,
                    input coeff_3, input coeff_4, input coeff_5, input coeff_6,
                    input coeff_7, output ready);
endinterface

FILE: sv/byte_ntt8_mod257_core.sv
// Top level of the byte-wise 8-point negacyclic NTT modulo 257.
//
// Each accepted input byte gives one word of eight coefficients, each the
// centred residue mod 257 in -128..128. One byte is taken per clock cycle
// unless out_ch.ready back-pressure stalls the pipeline or the power table
// is being rebuilt; a word passes through registered pair sums, full sums
// and the mod-257 fold into the output register. The seven root powers sit
// in a table rebuilt after reset and after every register write, with one
// multiply and an 18-step bit-serial remainder each; in_ch.ready stays low meanwhile.
module byte_ntt8_mod257_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [bntt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bntt_pkg::VAL_W-1:0]             cfg_wdata,
    bntt_in_if.sink                                in_ch,
    bntt_out_if.source                             out_ch
);

    localparam int N = bntt_pkg::NPTS;

    logic [bntt_pkg::VAL_W-1:0]  root_reg;
    logic [bntt_pkg::VAL_W-1:0]  mod_reg;
    bntt_pkg::pow_tab_t          tab;

    logic                        v1_reg, v2_reg, v3_reg;
    logic                        adv1, adv2, adv3;
    logic                        in_take;

    logic signed [bntt_pkg::PAIR_W-1:0] pair_next [N][N/2];
    logic signed [bntt_pkg::PAIR_W-1:0] pair_reg  [N][N/2];
    logic signed [bntt_pkg::SUM_W-1:0]  sum_next  [N];
    logic signed [bntt_pkg::SUM_W-1:0]  sum_reg   [N];
    logic signed [bntt_pkg::VAL_W-1:0]  coef_reg  [N];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= bntt_pkg::ROOT_RST;
            mod_reg  <= bntt_pkg::MODULUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bntt_pkg::CFG_ROOT:    root_reg <= cfg_wdata;
                bntt_pkg::CFG_MODULUS: mod_reg  <= cfg_wdata;
                default:               root_reg <= root_reg;
            endcase
        end
    end

    bntt_pow_gen u_pow_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_we),
        .root    (root_reg),
        .modulus (mod_reg),
        .tab     (tab)
    );

    // advance each stage when it is empty or the next one moves
    assign adv3    = !v3_reg || out_ch.ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign in_ch.ready = adv1 && !tab.busy;
    assign in_take = in_ch.valid && in_ch.ready;

    // stage 1: signed matrix terms, summed in pairs of input bits
    for (genvar j = 0; j < N; j++)
    begin : g_row
        for (genvar q = 0; q < N / 2; q++)
        begin : g_pair
            localparam logic [3:0] E0 = bntt_pkg::exp_of(j, 2 * q);
            localparam logic [3:0] E1 = bntt_pkg::exp_of(j, 2 * q + 1);
            logic signed [bntt_pkg::TERM_W-1:0] mag0, mag1, t0, t1;

            assign mag0 = $signed({1'b0, tab.pow[E0[2:0]]});
            assign mag1 = $signed({1'b0, tab.pow[E1[2:0]]});
            assign t0 = !in_ch.data_byte[2 * q] ? '0 : ((E0 > 4'd8) ? -mag0 : mag0);
            assign t1 = !in_ch.data_byte[2 * q + 1] ? '0 : ((E1 > 4'd8) ? -mag1 : mag1);
            assign pair_next[j][q] = bntt_pkg::PAIR_W'(t0) + bntt_pkg::PAIR_W'(t1);
        end

        // stage 2: full row sum
        assign sum_next[j] = bntt_pkg::SUM_W'(pair_reg[j][0])
                           + bntt_pkg::SUM_W'(pair_reg[j][1])
                           + bntt_pkg::SUM_W'(pair_reg[j][2])
                           + bntt_pkg::SUM_W'(pair_reg[j][3]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_take;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage payload registers; stage 3 folds mod 257 into the output word
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < N; j++)
        begin
            if (adv1)
            begin
                for (int q = 0; q < N / 2; q++)
                begin
                    pair_reg[j][q] <= pair_next[j][q];
                end
            end
            if (adv2)
            begin
                sum_reg[j] <= sum_next[j];
            end
            if (adv3)
            begin
                coef_reg[j] <= bntt_pkg::reduce_centre(sum_reg[j]);
            end
        end
    end

    assign out_ch.valid   = v3_reg;
    assign out_ch.coeff_0 = coef_reg[0];
    assign out_ch.coeff_1 = coef_reg[1];
    assign out_ch.coeff_2 = coef_reg[2];
    assign out_ch.coeff_3 = coef_reg[3];
    assign out_ch.coeff_4 = coef_reg[4];
    assign out_ch.coeff_5 = coef_reg[5];
    assign out_ch.coeff_6 = coef_reg[6];
    assign out_ch.coeff_7 = coef_reg[7];

endmodule

FILE: sv/bntt_pow_gen.sv
// Power table generator: omega^1..omega^7 by multiply and bit-serial remainder.
module bntt_pow_gen (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bntt_pkg::VAL_W-1:0]     root,
    input  logic [bntt_pkg::VAL_W-1:0]     modulus,
    output bntt_pkg::pow_tab_t             tab
);

    bntt_pkg::pw_state_t               state_reg, state_next;
    logic [bntt_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [bntt_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [bntt_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [bntt_pkg::VAL_W-1:0]        rem_reg, rem_next;
    logic [bntt_pkg::VAL_W-1:0]        pow_reg [1:bntt_pkg::NPTS-1];
    logic [bntt_pkg::NPTS-1:0][bntt_pkg::VAL_W-1:0] pow_all;
    logic [bntt_pkg::VAL_W-1:0]        pow_prev;
    logic [bntt_pkg::VAL_W:0]          mod_eff;
    logic [bntt_pkg::VAL_W:0]          trial;
    logic                              pow_we;

    // exponent zero is always one, never reduced
    always_comb
    begin
        pow_all[0] = bntt_pkg::VAL_W'(1);
        for (int i = 1; i < bntt_pkg::NPTS; i++)
        begin
            pow_all[i] = pow_reg[i];
        end
    end

    assign pow_prev = pow_all[idx_reg - bntt_pkg::IDX_W'(1)];
    assign mod_eff  = (modulus == '0) ? bntt_pkg::ZERO_MOD_EFF : {1'b0, modulus};
    assign trial    = {rem_reg, prod_reg[bntt_pkg::PROD_W-1]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            bntt_pkg::PW_IDLE:
            begin
                state_next = bntt_pkg::PW_IDLE;
            end
            bntt_pkg::PW_MUL:
            begin
                state_next = bntt_pkg::PW_DIV;
                cnt_next   = bntt_pkg::CNT_W'(bntt_pkg::PROD_W - 1);
            end
            bntt_pkg::PW_DIV:
            begin
                cnt_next = cnt_reg - bntt_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (idx_reg == bntt_pkg::IDX_W'(bntt_pkg::NPTS - 1))
                    begin
                        state_next = bntt_pkg::PW_IDLE;
                    end
                    else
                    begin
                        state_next = bntt_pkg::PW_MUL;
                        idx_next   = idx_reg + bntt_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = bntt_pkg::PW_IDLE;
            end
        endcase
        // restart on every register write
        if (start)
        begin
            state_next = bntt_pkg::PW_MUL;
            idx_next   = bntt_pkg::IDX_W'(1);
        end
    end

    // datapath outputs of each state
    always_comb
    begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        pow_we    = 1'b0;
        unique case (state_reg)
            bntt_pkg::PW_IDLE:
            begin
                pow_we = 1'b0;
            end
            bntt_pkg::PW_MUL:
            begin
                prod_next = bntt_pkg::PROD_W'(pow_prev) * bntt_pkg::PROD_W'(root);
                rem_next  = '0;
            end
            bntt_pkg::PW_DIV:
            begin
                prod_next = prod_reg << 1;
                if (trial >= mod_eff)
                begin
                    rem_next = bntt_pkg::VAL_W'(trial - mod_eff);
                end
                else
                begin
                    rem_next = trial[bntt_pkg::VAL_W-1:0];
                end
                pow_we = (cnt_reg == '0);
            end
            default:
            begin
                pow_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bntt_pkg::PW_MUL;
            idx_reg   <= bntt_pkg::IDX_W'(1);
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    // working registers and power table
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        if (pow_we)
        begin
            pow_reg[idx_reg] <= rem_next;
        end
    end

    assign tab.busy = (state_reg != bntt_pkg::PW_IDLE);
    assign tab.pow  = pow_all;

endmodule
